// File: src/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Beat layouts, command and status codes, cell operations and the control
// bundle that the controller hands to the row of storage cells.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int CMD_W    = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What one cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_LOAD      = 2'd1,
		CELL_FROM_PREV = 2'd2,
		CELL_FROM_NEXT = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] push_value;
	} in_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   read_value;
		logic [FILL_W-1:0]   fill_count;
	} out_beat_t;

	typedef struct packed {
		cell_op_t [DEPTH-1:0] op;
		status_t              status;
		logic                 rd_en;
		logic                 rd_back;
		logic [CNT_W-1:0]     count;
		logic [CNT_W-1:0]     count_next;
	} dq_ctl_t;

endpackage
`default_nettype wire

// File: src/dq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one word; loads a new word or takes the word of either neighbor.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
(
	input  wire logic                  clk,
	input  cell_op_t                   op,
	input  wire logic [DATA_WIDTH-1:0] new_data,
	input  wire logic [DATA_WIDTH-1:0] prev_data,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	output logic      [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		unique case (op)
			CELL_HOLD:      data_d = data_q;
			CELL_LOAD:      data_d = new_data;
			CELL_FROM_PREV: data_d = prev_data;
			CELL_FROM_NEXT: data_d = next_data;
			default:        data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

// File: src/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl: command decoder and entry counter
// Decodes each accepted command into per-cell operations, status and the
// read selection; keeps the entry count. The front entry always sits in cell 0.
// ----------------------------------------------------------------------------
module dq_ctrl
	import dq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [CMD_W-1:0] cmd,
	input  wire logic [CAP_W-1:0] cap,
	output dq_ctl_t               ctl
);

	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;

	assign full  = (32'(count_q) >= 32'(DEPTH)) || (32'(count_q) >= 32'(cap));
	assign empty = (count_q == '0);

	always_comb begin
		ctl            = '0;
		ctl.count      = count_q;
		ctl.count_next = count_q;
		ctl.status     = ST_OK;
		for (int i = 0; i < DEPTH; i++) begin
			ctl.op[i] = CELL_HOLD;
		end
		unique case (cmd) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.count_next = count_q + CNT_W'(1);
					for (int i = 0; i < DEPTH; i++) begin
						if (cmd == CMD_PUSH_FRONT) begin
							ctl.op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
						end else if (CNT_W'(i) == count_q) begin
							ctl.op[i] = CELL_LOAD;
						end
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_back = (cmd == CMD_POP_BACK) || (cmd == CMD_PEEK_BACK);
					if (cmd == CMD_POP_FRONT) begin
						ctl.count_next = count_q - CNT_W'(1);
						for (int i = 0; i < DEPTH; i++) begin
							ctl.op[i] = CELL_FROM_NEXT;
						end
					end else if (cmd == CMD_POP_BACK) begin
						ctl.count_next = count_q - CNT_W'(1);
					end
				end
			end
			CMD_CLEAR: begin
				ctl.count_next = '0;
			end
			default: begin
				ctl.count_next = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= ctl.count_next;
		end
	end

endmodule
`default_nettype wire

// File: src/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of data words
// Push, pop and peek at either end, plus clear, on a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : command beat {cmd, push_value}, valid/stall handshake; a beat is
//            taken at an edge with in_valid high and in_stall low.
//   out_*  : one result beat {status, read_value, fill_count} per command.
//   cfg_*  : write capacity_limit while the queue is idle; cfg_ready is
//            always high, so a write lands at the edge where cfg_valid is high.
// The result is registered: it shows on out_data the cycle after the
// command beat is taken. The queue takes one command per cycle while
// in_stall is low; every command finishes in the cycle it is taken, since
// the cell row and the entry counter update at the edge that takes it.
// The front entry always sits in cell 0: push front shifts the row toward
// the back, pop front shifts it toward the front, push back loads the cell
// at the current count, pop back only drops the count.
// A stalled result holds in the output register; in_stall rises only while
// a result waits and out_stall is high, so input takes a new beat in the
// same cycle the old result leaves.
// Reset empties the queue and sets the capacity to 16; the cells keep their
// contents, which are never read before a push writes them.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_beat_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	logic                  accept;
	logic                  out_valid_q;
	out_beat_t             out_data_q;
	logic [CAP_W-1:0]      cap_q;
	dq_ctl_t               ctl;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] new_word;
	logic [IDX_W-1:0]      back_idx;
	logic [DATA_WIDTH-1:0] rd_word;
	out_beat_t             result;

	// Stall only while a finished result is still held by the receiver.
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (in_data.cmd),
		.cap    (cap_q),
		.ctl    (ctl)
	);

	assign new_word = DATA_WIDTH'(in_data.push_value);

	// Row of cells; the ends hand their own word back where no neighbor exists.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_word;
		logic [DATA_WIDTH-1:0] next_word;
		cell_op_t              op;

		if (i == 0) begin : g_first
			assign prev_word = cell_data[i];
		end else begin : g_prev
			assign prev_word = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_word = cell_data[i];
		end else begin : g_next
			assign next_word = cell_data[i+1];
		end

		// Hold every cell unless a command beat is actually taken.
		assign op = accept ? ctl.op[i] : CELL_HOLD;

		dq_cell u_cell (
			.clk       (clk),
			.op        (op),
			.new_data  (new_word),
			.prev_data (prev_word),
			.next_data (next_word),
			.data      (cell_data[i])
		);
	end

	// Back entry sits at count - 1; front entry is cell 0.
	assign back_idx = IDX_W'(ctl.count - CNT_W'(1));
	assign rd_word  = ctl.rd_back ? cell_data[back_idx] : cell_data[0];

	always_comb begin
		result.status     = ctl.status;
		result.read_value = ctl.rd_en ? WORD_W'(rd_word) : '0;
		result.fill_count = FILL_W'(ctl.count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
